// File: sv/fsfc_pkg.sv
// fsfc_pkg: shared types and constants for the filtered serial frame counter
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fsfc_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned THR_W      = 4;
  localparam int unsigned CNT_W      = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BIT_THRESHOLD = 2'd0,
    CFG_DAY_END       = 2'd1,
    CFG_HOUR_END      = 2'd2,
    CFG_FRAME_END     = 2'd3
  } cfg_idx_t;

  localparam logic [THR_W-1:0] THR_RESET       = 4'd2;
  localparam logic [CNT_W-1:0] DAY_END_RESET   = 8'd18;
  localparam logic [CNT_W-1:0] HOUR_END_RESET  = 8'd48;
  localparam logic [CNT_W-1:0] FRAME_END_RESET = 8'd120;
  localparam logic [CNT_W-1:0] CNT_MAX         = 8'hFF;

  typedef struct packed {
    logic clr;
    logic shift;
  } win_ctl_t;

endpackage

`default_nettype wire

// File: sv/fsfc_win.sv
// fsfc_win: sliding sample window with a count of ones in the shifted window
// depends on fsfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsfc_win
  import fsfc_pkg::*;
#(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned CW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire win_ctl_t      ctl,
  input  wire logic          bit_in,
  output logic      [CW-1:0] ones
);

  logic [WIDTH-1:0] win_r;
  logic [WIDTH-1:0] win_nxt;

  assign win_nxt = {win_r[WIDTH-2:0], bit_in};

  // ones in the window as it stands after this sample
  always_comb begin
    ones = '0;
    for (int i = 0; i < WIDTH; i++) begin
      ones = ones + CW'(win_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.clr) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/filtered_serial_frame_counter_top.sv
// filtered_serial_frame_counter_top: decodes one serial frame from oversampled pins
// depends on fsfc_pkg and fsfc_win
//
// usage
//   in_*  : one transaction per oversampled tick, in_tdata[0] clock pin,
//           in_tdata[1] data pin
//   out_* : one transaction per finished frame with edge total and the
//           day, hour and minute ones counts, 8 bits each
//   cfg_* : register writes; the user must make them only while no frame is in flight, the block does not enforce it
//   a high clock sample while idle starts a frame; the frame ends on the first
//   qualified rising edge whose count is at least frame_end, day_end and hour_end
//   a tick is registered in the input register on acceptance and is evaluated
//   once the result slot is free; the ending tick's result goes to the result register
//   throughput: 1 tick per cycle while the result slot is free, set by the
//   input register feeding the window count and counter update
//   reset: idle, windows and counters cleared, registers at defaults
//   stall: while out_tready is low with a result pending, one more tick is
//   held in the input register and then in_tready drops
`timescale 1ns / 1ps
`default_nettype none

module filtered_serial_frame_counter_top
  import fsfc_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // clock_line, data_line
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,  // edge_total, day_ones, hour_ones, minute_ones
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned CMPW = (CW > THR_W) ? CW : THR_W;

  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] day_end_r;
  logic [CNT_W-1:0] hour_end_r;
  logic [CNT_W-1:0] frame_end_r;

  logic             s1_valid_r;
  logic             s1_clk_r;
  logic             s1_dat_r;

  logic             active_r, active_nxt;
  logic             qual_r, qual_nxt;
  logic [CNT_W-1:0] edge_r, edge_nxt;
  logic [CNT_W-1:0] day_r, day_nxt;
  logic [CNT_W-1:0] hour_r, hour_nxt;
  logic [CNT_W-1:0] min_r, min_nxt;

  logic             out_valid_r;
  logic [31:0]      out_data_r;

  logic             go;
  logic             emit;
  win_ctl_t         wctl;
  logic [CW-1:0]    clk_ones;
  logic [CW-1:0]    dat_ones;
  logic             clk_hi;
  logic             dat_hi;
  logic [CNT_W-1:0] edge_inc;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      day_end_r   <= DAY_END_RESET;
      hour_end_r  <= HOUR_END_RESET;
      frame_end_r <= FRAME_END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_BIT_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
        CFG_DAY_END:       day_end_r   <= cfg_wdata;
        CFG_HOUR_END:      hour_end_r  <= cfg_wdata;
        CFG_FRAME_END:     frame_end_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // evaluate the held tick when the result slot is free
  assign go        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_clk_r <= in_tdata[0];
      s1_dat_r <= in_tdata[1];
    end
  end

  assign wctl.clr   = go && !active_r && s1_clk_r;
  assign wctl.shift = go && active_r;

  fsfc_win #(.WIDTH(WINDOW), .CW(CW)) u_clk_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (wctl),
    .bit_in (s1_clk_r),
    .ones   (clk_ones)
  );

  fsfc_win #(.WIDTH(WINDOW), .CW(CW)) u_dat_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (wctl),
    .bit_in (s1_dat_r),
    .ones   (dat_ones)
  );

  assign clk_hi   = CMPW'(clk_ones) > CMPW'(thr_r);
  assign dat_hi   = CMPW'(dat_ones) > CMPW'(thr_r);
  assign edge_inc = (edge_r == CNT_MAX) ? CNT_MAX : edge_r + 1'b1;

  always_comb begin
    active_nxt = active_r;
    qual_nxt   = qual_r;
    edge_nxt   = edge_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    emit       = 1'b0;
    if (go) begin
      if (!active_r) begin
        if (s1_clk_r) begin
          active_nxt = 1'b1;
          qual_nxt   = 1'b0;
          edge_nxt   = '0;
          day_nxt    = '0;
          hour_nxt   = '0;
          min_nxt    = '0;
        end
      end else if (!qual_r && clk_hi) begin
        qual_nxt = 1'b1;
        edge_nxt = edge_inc;
        if (edge_inc < day_end_r) begin
          if (dat_hi && day_r != CNT_MAX) day_nxt = day_r + 1'b1;
        end else if (edge_inc < hour_end_r) begin
          if (dat_hi && hour_r != CNT_MAX) hour_nxt = hour_r + 1'b1;
        end else if (edge_inc < frame_end_r) begin
          if (dat_hi && min_r != CNT_MAX) min_nxt = min_r + 1'b1;
        end else begin
          emit       = 1'b1;
          active_nxt = 1'b0;
        end
      end else if (qual_r && !clk_hi) begin
        qual_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      qual_r   <= 1'b0;
      edge_r   <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      min_r    <= '0;
    end else begin
      active_r <= active_nxt;
      qual_r   <= qual_nxt;
      edge_r   <= edge_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      min_r    <= min_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {min_r, hour_r, day_r, edge_inc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: sv/fsfc_chk.sv
// fsfc_chk: port-level checks for the filtered serial frame counter
// depends on filtered_serial_frame_counter_top, attached by bind
`timescale 1ns / 1ps
`default_nettype none

module fsfc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a frame ends on a counted edge
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] != 8'd0)
    else $error("result with zero edges");

  // segment counts never exceed the edges seen
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:8] <= out_tdata[7:0] &&
                   out_tdata[23:16] <= out_tdata[7:0] &&
                   out_tdata[31:24] <= out_tdata[7:0])
    else $error("segment count above edge total");

endmodule

bind filtered_serial_frame_counter_top fsfc_chk u_fsfc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/filtered_serial_frame_counter_checker.sv
// filtered_serial_frame_counter_checker: watches the tick, result and register ports,
// predicts every finished frame and compares it field by field with the block's output
// depends on fsfc_pkg
`timescale 1ns / 1ps

module filtered_serial_frame_counter_checker
  import fsfc_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // clock_line, data_line
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,  // edge_total, day_ones, hour_ones, minute_ones
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    frames_owed,
  output logic                  frame_open
);

  typedef struct packed {
    logic [CNT_W-1:0] minute_ones;
    logic [CNT_W-1:0] hour_ones;
    logic [CNT_W-1:0] day_ones;
    logic [CNT_W-1:0] edge_total;
  } frame_tally_t;

  logic [THR_W-1:0]  thr;
  logic [CNT_W-1:0]  day_end;
  logic [CNT_W-1:0]  hour_end;
  logic [CNT_W-1:0]  frame_end;
  logic [WINDOW-1:0] clk_win;
  logic [WINDOW-1:0] dat_win;
  logic              clk_q;
  logic [CNT_W-1:0]  edges;
  logic [CNT_W-1:0]  day_cnt;
  logic [CNT_W-1:0]  hour_cnt;
  logic [CNT_W-1:0]  min_cnt;
  frame_tally_t      tallies_due[$];

  function automatic int unsigned ones_in_window(input logic [WINDOW-1:0] w);
    int unsigned n;
    n = 0;
    for (int i = 0; i < WINDOW; i++) n += w[i];
    return n;
  endfunction

  task automatic clear_frame_state();
    clk_win  = '0;
    dat_win  = '0;
    clk_q    = 1'b0;
    edges    = '0;
    day_cnt  = '0;
    hour_cnt = '0;
    min_cnt  = '0;
  endtask

  task automatic sample_tick(input logic c, input logic d, output bit done,
                             output frame_tally_t tally);
    int unsigned clk_ones;
    bit          data_one;
    done  = 1'b0;
    tally = '0;
    if (!frame_open) begin
      if (c) begin
        frame_open = 1'b1;
        clear_frame_state();
      end
      return;
    end
    clk_win  = {clk_win[WINDOW-2:0], c};
    dat_win  = {dat_win[WINDOW-2:0], d};
    clk_ones = ones_in_window(clk_win);
    if (!clk_q && clk_ones > thr) begin
      clk_q = 1'b1;
      if (edges != CNT_MAX) edges++;
      data_one = ones_in_window(dat_win) > thr;
      // segment tests in fixed order, first hit wins
      if (edges < day_end) begin
        if (data_one && day_cnt != CNT_MAX) day_cnt++;
      end else if (edges < hour_end) begin
        if (data_one && hour_cnt != CNT_MAX) hour_cnt++;
      end else if (edges < frame_end) begin
        if (data_one && min_cnt != CNT_MAX) min_cnt++;
      end else begin
        tally.edge_total  = edges;
        tally.day_ones    = day_cnt;
        tally.hour_ones   = hour_cnt;
        tally.minute_ones = min_cnt;
        done              = 1'b1;
        frame_open        = 1'b0;
      end
    end else if (clk_q && clk_ones <= thr) begin
      clk_q = 1'b0;
    end
  endtask

  always @(posedge clk) begin : track
    frame_tally_t seen;
    frame_tally_t want;
    frame_tally_t fresh;
    bit           done;
    if (!rst_n) begin
      thr        = THR_RESET;
      day_end    = DAY_END_RESET;
      hour_end   = HOUR_END_RESET;
      frame_end  = FRAME_END_RESET;
      frame_open = 1'b0;
      fail_count = 0;
      clear_frame_state();
      tallies_due.delete();
    end else begin
      // results first, so a tick taken at the same edge cannot match them
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (tallies_due.size() == 0) begin
          $error("frame result %h with no frame pending", out_tdata);
          fail_count++;
        end else begin
          want = tallies_due.pop_front();
          if (seen.edge_total != want.edge_total) begin
            $error("edge_total mismatch: expected %0d, actual %0d",
                   want.edge_total, seen.edge_total);
            fail_count++;
          end
          if (seen.day_ones != want.day_ones) begin
            $error("day_ones mismatch: expected %0d, actual %0d",
                   want.day_ones, seen.day_ones);
            fail_count++;
          end
          if (seen.hour_ones != want.hour_ones) begin
            $error("hour_ones mismatch: expected %0d, actual %0d",
                   want.hour_ones, seen.hour_ones);
            fail_count++;
          end
          if (seen.minute_ones != want.minute_ones) begin
            $error("minute_ones mismatch: expected %0d, actual %0d",
                   want.minute_ones, seen.minute_ones);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_BIT_THRESHOLD: thr       = cfg_wdata[THR_W-1:0];
          CFG_DAY_END:       day_end   = cfg_wdata[CNT_W-1:0];
          CFG_HOUR_END:      hour_end  = cfg_wdata[CNT_W-1:0];
          CFG_FRAME_END:     frame_end = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        sample_tick(in_tdata[0], in_tdata[1], done, fresh);
        if (done) tallies_due.push_back(fresh);
      end
    end
    frames_owed = tallies_due.size();
  end

endmodule

// File: tb/tb_filtered_serial_frame_counter_top.sv
// tb_filtered_serial_frame_counter_top: drives oversampled clock and data ticks, register
// settings and result back-pressure into the frame counter and reports the verdict
// depends on fsfc_pkg, filtered_serial_frame_counter_top and the frame counter checker
`timescale 1ns / 1ps

module tb_filtered_serial_frame_counter_top;
  import fsfc_pkg::*;

  localparam int unsigned WINDOW          = 10;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // clock_line, data_line
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;  // edge_total, day_ones, hour_ones, minute_ones
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    frames_owed;
  logic                  frame_open;
  logic                  idling;
  logic                  hold_req;
  int unsigned           cur_thr;

  filtered_serial_frame_counter_top #(.WINDOW(WINDOW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  filtered_serial_frame_counter_checker #(.WINDOW(WINDOW)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .frames_owed(frames_owed), .frame_open(frame_open)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_filtered_serial_frame_counter_top failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit held;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic push_tick(input logic c, input logic d);
    if (idling && $urandom_range(0, 11) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tdata  <= {6'd0, d, c};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pulse(input int unsigned hi, input int unsigned lo, input logic d,
                            input bit noisy);
    for (int unsigned k = 0; k < hi + lo; k++)
      push_tick((k < hi) ^ (noisy && $urandom_range(0, 11) == 0),
                d ^ (noisy && $urandom_range(0, 11) == 0));
  endtask

  task automatic set_config(input logic [7:0] thr_v, input logic [7:0] day_v,
                            input logic [7:0] hour_v, input logic [7:0] frame_v);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_BIT_THRESHOLD;
    cfg_wdata <= thr_v;
    @(negedge clk);
    cfg_addr  <= CFG_DAY_END;
    cfg_wdata <= day_v;
    @(negedge clk);
    cfg_addr  <= CFG_HOUR_END;
    cfg_wdata <= hour_v;
    @(negedge clk);
    cfg_addr  <= CFG_FRAME_END;
    cfg_wdata <= frame_v;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_thr = thr_v[THR_W-1:0];
  endtask

  task automatic random_config();
    logic [7:0] t;
    logic [7:0] d;
    logic [7:0] h;
    logic [7:0] f;
    t = 8'($urandom_range(0, 9));
    if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 1) ? 8'd9 : 8'd0;
    t[7:4] = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0) begin
      d = 8'($urandom_range(0, 20));
      h = 8'($urandom_range(0, 20));
      f = 8'($urandom_range(0, 20));
    end else begin
      d = 8'($urandom_range(0, 4));
      h = 8'(d + $urandom_range(0, 5));
      f = 8'(h + $urandom_range(0, 5));
    end
    set_config(t, d, h, f);
  endtask

  // mostly clean clock pulses with a steady data level, some glitchy, some noise
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned hi;
    int unsigned lo;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        hi = $urandom_range(1, 12);
        lo = $urandom_range(1, 12);
        send_pulse(hi, lo, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        sent += hi + lo;
      end else begin
        hi = $urandom_range(1, 8);
        repeat (hi) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent += hi;
      end
    end
  endtask

  // shortest clean pulse train for the current threshold until the frame ends
  task automatic close_frame();
    int unsigned k;
    logic        d;
    k = 0;
    d = 1'($urandom_range(0, 1));
    while (frame_open) begin
      push_tick(k <= cur_thr, d);
      k = (k == WINDOW) ? 0 : k + 1;
      if (k == 0) d = 1'($urandom_range(0, 1));
    end
    in_tvalid <= 1'b0;
    while (frames_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_BIT_THRESHOLD;
    cfg_wdata = '0;
    idling    = 1'b1;
    hold_req  = 1'b0;
    cur_thr   = THR_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: idle ticks with clock low and the first edges of a frame,
    // then short segments finish the same frame
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    send_pulse(5, 6, 1'b1, 1'b0);
    send_pulse(3, 8, 1'b0, 1'b0);
    in_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    set_config(8'd2, 8'd4, 8'd6, 8'd8);
    close_frame();

    // zero ends: first edge ends the frame, the ending tick never restarts
    set_config(8'd0, 8'd0, 8'd0, 8'd0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    close_frame();

    // strictest threshold that still qualifies
    set_config(8'd9, 8'd2, 8'd4, 8'd5);
    run_phase(30);
    close_frame();

    // segment ends out of order
    set_config(8'd0, 8'd3, 8'd1, 8'd6);
    run_phase(40);
    close_frame();

    repeat (3) begin
      random_config();
      run_phase(45);
      close_frame();
    end

    // receiver holds off while short frames keep finishing
    set_config(8'd0, 8'd0, 8'd0, 8'd1);
    hold_req <= 1'b1;
    repeat (40) push_tick(1'b1, 1'($urandom_range(0, 1)));
    close_frame();

    idling <= 1'b0;
    random_config();
    run_phase(40);
    close_frame();

    // threshold of a full window with upper data bits set: no frame can end
    set_config(8'hFA, 8'd2, 8'd4, 8'd6);
    run_phase(20);
    in_tvalid <= 1'b0;

    while (frames_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && frames_owed == 0)
      $display("tb_filtered_serial_frame_counter_top passed");
    else
      $display("tb_filtered_serial_frame_counter_top failed");
    $finish;
  end

endmodule
